[rtl/double_ended_queue_with_search_assert.svh]
// Assertion helpers for the deque block.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH

// Checked on every rising edge while out of reset.
`define DQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DQS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dqs_pkg.sv]
`timescale 1ns / 1ps
package dqs_pkg;

  localparam int OP_W  = 3;
  localparam int KEY_W = 32;
  // op + key, padded to whole bytes
  localparam int IN_DW = 40;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_DELETE     = 3'd5
  } op_e;

  typedef struct packed {
    logic valid;
    logic ok;
  } res_flags_t;

endpackage

[rtl/dqs_mem.sv]
`timescale 1ns / 1ps
module dqs_mem
  import dqs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem_r [DEPTH];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/dqs_ctrl.sv]
`timescale 1ns / 1ps
`include "double_ended_queue_with_search_assert.svh"
module dqs_ctrl
  import dqs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  // request side
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [OP_W-1:0]  req_op,
  input  logic [KEY_W-1:0] req_key,
  // result side
  input  logic             res_ready,
  output res_flags_t       res_flags,
  output logic [KEY_W-1:0] res_key,
  output logic [CW-1:0]    res_count,
  // store port
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [KEY_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [KEY_W-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    front_r, front_nxt;
  logic [CW-1:0]    held_r, held_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] kout_r, kout_nxt;
  logic             ok_r, ok_nxt;
  logic             del_r, del_nxt;

  logic accept, full, empty, imm, imm_ok, hit, last;
  logic [AW-1:0] front_dec, front_inc;

  // ring slot of the entry pos places behind the front; sum < 2*DEPTH
  function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                               input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, pos};
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign req_ready = (state_r == ST_IDLE) && res_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (held_r == CW'(DEPTH));
  assign empty     = (held_r == '0);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign hit       = (mem_rdata == key_r);
  assign last      = ((pos_r + CW'(1)) == held_r);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    held_nxt  = held_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    kout_nxt  = kout_r;
    ok_nxt    = ok_r;
    del_nxt   = del_r;
    imm       = 1'b0;
    imm_ok    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = front_r;
    mem_wdata = req_key;
    mem_re    = 1'b0;
    mem_raddr = front_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt  = req_key;
          kout_nxt = '0;
          ok_nxt   = 1'b0;
          del_nxt  = (req_op == OP_DELETE);
          unique case (req_op)
            OP_PUSH_FRONT: begin
              imm = 1'b1;
              if (!full) begin
                front_nxt = front_dec;
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                held_nxt  = held_r + CW'(1);
                imm_ok    = 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              imm = 1'b1;
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = wrap_slot(front_r, held_r);
                held_nxt  = held_r + CW'(1);
                imm_ok    = 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                imm = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                front_nxt = front_inc;
                held_nxt  = held_r - CW'(1);
                state_nxt = ST_POP;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                imm = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = wrap_slot(front_r, held_r - CW'(1));
                held_nxt  = held_r - CW'(1);
                state_nxt = ST_POP;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              if (empty) begin
                imm = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                pos_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              imm = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        kout_nxt  = mem_rdata;
        ok_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        // data for pos_r arrives now; fetch the next one in parallel
        mem_re    = 1'b1;
        mem_raddr = wrap_slot(front_r, pos_r + CW'(1));
        pos_nxt   = pos_r + CW'(1);
        if (hit) begin
          ok_nxt = 1'b1;
          if (del_r && !last) begin
            pos_nxt   = pos_r;
            state_nxt = ST_SHIFT;
          end else begin
            if (del_r) begin
              held_nxt = held_r - CW'(1);
            end
            state_nxt = ST_DONE;
          end
        end else if (last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        // pos_r is the hole; its successor's data is on mem_rdata
        mem_we    = 1'b1;
        mem_waddr = wrap_slot(front_r, pos_r);
        mem_wdata = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = wrap_slot(front_r, pos_r + CW'(2));
        pos_nxt   = pos_r + CW'(1);
        if ((pos_r + CW'(2)) == held_r) begin
          held_nxt  = held_r - CW'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      held_r  <= held_nxt;
    end
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    kout_r <= kout_nxt;
    ok_r   <= ok_nxt;
    del_r  <= del_nxt;
  end

  always_comb begin
    if (state_r == ST_DONE) begin
      res_flags.valid = 1'b1;
      res_flags.ok    = ok_r;
      res_key         = kout_r;
      res_count       = held_r;
    end else begin
      res_flags.valid = imm;
      res_flags.ok    = imm_ok;
      res_key         = '0;
      res_count       = held_nxt;
    end
  end

  `DQS_ASSERT(a_held_bound, held_r <= CW'(DEPTH), "held count beyond depth")
  `DQS_ASSERT(a_we_states, mem_we |-> (state_r == ST_IDLE || state_r == ST_SHIFT),
              "store written outside push or shift")
  `DQS_ASSERT(a_scan_pos, (state_r == ST_SCAN) |-> (pos_r < held_r),
              "scan position past last held key")
  `DQS_ASSERT(a_push_grow,
              (accept && !full && (req_op == OP_PUSH_FRONT || req_op == OP_PUSH_BACK))
              |=> (held_r == $past(held_r) + CW'(1)), "push did not grow count")

endmodule

[rtl/double_ended_queue_with_search.sv]
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit keys in a DEPTH-entry ring
// store (one synchronous RAM, one write and one read port, registered read).
// Each request carries an op (push front/back, pop front/back, search,
// delete first match) and returns exactly one result: ok, popped key
// (zero unless a pop succeeded) and the count held afterwards. Pushes and
// all refused or empty-queue requests answer in the accept cycle. Pops
// go through accept with the RAM read issued, capture of the read key,
// then the result state. Search and delete scan one entry per cycle
// through the read port; delete then moves each later key one slot
// forward, reading the next entry while writing the previous one. The
// single RAM read port sets that scan rate. One request is in work at a
// time; a finished result sits in the output register, and the next
// request is taken in the same cycle that register is drained. No
// clearing pass after reset: only held entries are ever read.
module double_ended_queue_with_search
  import dqs_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DW-1:0]     in_tdata,   // [2:0] op, [34:3] key, rest zero
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [((33 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                               out_tdata   // [0] ok, [32:1] key_out, then count
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int OUT_DW = ((33 + CW + 7) / 8) * 8;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [KEY_W-1:0] mem_wdata, mem_rdata;

  res_flags_t              res_flags;
  logic signed [KEY_W-1:0] res_key;
  logic [CW-1:0]           res_count;
  logic                    res_ready;

  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;

  // output register frees in the same cycle it is drained
  assign res_ready = !out_valid_r || out_tready;

  dqs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tdata[OP_W-1:0]),
    .req_key   (in_tdata[OP_W +: KEY_W]),
    .res_ready (res_ready),
    .res_flags (res_flags),
    .res_key   (res_key),
    .res_count (res_count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  dqs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // pack result: ok, key_out, count from bit 0 up, zero fill
  always_comb begin
    out_data_nxt             = '0;
    out_data_nxt[0]          = res_flags.ok;
    out_data_nxt[1 +: KEY_W] = res_key;
    out_data_nxt[33 +: CW]   = res_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_flags.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_flags.valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
